/* src/fprs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fprs_pkg: shared types and constants
// Sizes, command and status codes, and sequencer states of the plane scheduler.
// ----------------------------------------------------------------------------
package fprs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_SOURCES = 8;
    localparam int TIME_BITS   = 48;
    localparam int NUM_OPS     = 4;
    localparam int NUM_QUEUES  = NUM_OPS * NUM_SOURCES;
    localparam int QW          = $clog2(NUM_QUEUES);
    localparam int PW          = $clog2(QUEUE_DEPTH);
    localparam int CW          = $clog2(QUEUE_DEPTH + 1);
    localparam int SW          = $clog2(NUM_SOURCES);
    localparam int ENTRIES     = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW          = $clog2(ENTRIES);
    localparam int EW          = 64 + TIME_BITS + 1;

    localparam logic [1:0] CMD_ENQ    = 2'd0;
    localparam logic [1:0] CMD_DEQ    = 2'd1;
    localparam logic [1:0] CMD_CHOOSE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    localparam logic [1:0] OP_READ = 2'd0;

    localparam logic [2:0] SRC_USER         = 3'd0;
    localparam logic [2:0] SRC_MAPPING      = 3'd1;
    localparam logic [2:0] SRC_RECOVERY     = 3'd2;
    localparam logic [2:0] SRC_REPLAY       = 3'd3;
    localparam logic [2:0] SRC_MAINT        = 3'd4;
    localparam logic [2:0] SRC_REFRESH      = 3'd5;
    localparam logic [2:0] SRC_HOST_REFRESH = 3'd6;

    localparam logic [2:0] LOWEST_PRIORITY = 3'd5;

    localparam logic [1:0] REG_AGING  = 2'd0;
    localparam logic [1:0] REG_STARVE = 2'd1;
    localparam logic [1:0] REG_STREAK = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEQ_RD,
        S_DEQ_CHK,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DONE
    } state_t;

    function automatic logic [2:0] base_level(input logic [1:0] op,
                                              input logic [SW-1:0] src,
                                              input logic crit);
        logic [2:0] s;
        logic urgent;
        s = 3'(src);
        urgent = (s == SRC_RECOVERY) || (s == SRC_REPLAY);
        if (src > SW'(7))
            base_level = LOWEST_PRIORITY;
        else if (urgent && crit)
            base_level = 3'd0;
        else if (s == SRC_USER && op == OP_READ)
            base_level = 3'd1;
        else if (urgent)
            base_level = 3'd2;
        else if (s == SRC_USER || s == SRC_MAPPING)
            base_level = 3'd3;
        else if (s == SRC_MAINT || s == SRC_REFRESH || s == SRC_HOST_REFRESH)
            base_level = 3'd4;
        else
            base_level = LOWEST_PRIORITY;
    endfunction

endpackage
`default_nettype wire

/* src/fprs_entry_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fprs_entry_ram: queue entry store
// One write port and one registered read port for id, time and critical bit.
// ----------------------------------------------------------------------------
module fprs_entry_ram
    import fprs_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [EW-1:0] wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [EW-1:0] rd_data
);

    logic [EW-1:0] mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

/* src/flash_plane_request_scheduler_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// flash_plane_request_scheduler_top: request scheduler for one flash plane
// FIFO per (operation, source) pair, enqueue, dequeue and aged choose.
// ----------------------------------------------------------------------------
// Enqueue finishes on acceptance; dequeue passes a read and a check state;
// choose reads the queue heads one after another through the single entry
// RAM read port and compares each in a shared comparator, alternating read
// and compare states. The block takes one request at a time; the result sits
// in an output register until taken, and a new request is accepted in the
// same cycle the result leaves. No clearing pass: queue counts reset at once.
// ----------------------------------------------------------------------------
module flash_plane_request_scheduler_top
    import fprs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           cmd,
    input  wire logic [1:0]           op,
    input  wire logic [2:0]           source,
    input  wire logic [63:0]          request_id,
    input  wire logic [47:0]          enq_time,
    input  wire logic                 critical,
    input  wire logic                 update_streak,
    input  wire logic [47:0]          now,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [1:0]                status,
    output logic                      found,
    output logic [63:0]               chosen_id,
    output logic [1:0]                chosen_op,
    output logic [2:0]                chosen_source,
    output logic [2:0]                chosen_priority,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [47:0]          cfg_data
);

    state_t state_reg, state_next;

    logic [47:0] aging_reg, starve_reg;
    logic [15:0] streak_limit_reg, streak_reg;
    logic [PW-1:0] head_reg  [NUM_QUEUES];
    logic [CW-1:0] count_reg [NUM_QUEUES];

    // latched request
    logic [1:0]  op_reg;
    logic [2:0]  src_reg;
    logic [63:0] id_reg;
    logic        upd_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [QW-1:0] scan_reg;

    // best candidate
    logic        have_reg;
    logic [2:0]  bpri_reg;
    logic [TIME_BITS-1:0] btime_reg;
    logic [63:0] bid_reg;
    logic [QW-1:0] bq_reg;

    // output register
    logic        ovalid_reg;
    logic [1:0]  status_reg;
    logic        found_reg;
    logic [63:0] cid_reg;
    logic [1:0]  cop_reg;
    logic [2:0]  csrc_reg;
    logic [2:0]  cpri_reg;

    logic          accept;
    logic          finish;
    logic          src_ok;
    logic [QW-1:0] q_in, q_lat;
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;
    logic [PW:0]   slot_sum;
    logic [PW-1:0] slot;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;
    assign in_stall  = !(state_reg == S_IDLE) || (ovalid_reg && out_stall);
    assign src_ok    = 32'(source) < NUM_SOURCES;
    assign q_in      = QW'(32'(op) * NUM_SOURCES + 32'(source));
    assign q_lat     = QW'(32'(op_reg) * NUM_SOURCES + 32'(src_reg));

    // enqueue and invalid requests finish at once; dequeue and choose in their last state
    assign finish = (state_reg == S_IDLE && accept
                     && !(cmd == CMD_CHOOSE || (cmd == CMD_DEQ && src_ok)))
                 || state_reg == S_DEQ_CHK || state_reg == S_DONE;

    assign slot_sum = (PW+1)'(head_reg[q_in]) + (PW+1)'(count_reg[q_in]);
    assign slot     = (slot_sum >= (PW+1)'(QUEUE_DEPTH))
                    ? PW'(slot_sum - (PW+1)'(QUEUE_DEPTH)) : PW'(slot_sum);

    assign ram_we    = accept && cmd == CMD_ENQ && src_ok
                    && count_reg[q_in] < CW'(QUEUE_DEPTH);
    assign ram_waddr = AW'(32'(q_in) * QUEUE_DEPTH + 32'(slot));
    assign ram_wdata = {request_id, TIME_BITS'(enq_time), critical};

    always_comb
    begin
        if (state_reg == S_SCAN_RD)
            ram_raddr = AW'(32'(scan_reg) * QUEUE_DEPTH + 32'(head_reg[scan_reg]));
        else
            ram_raddr = AW'(32'(q_lat) * QUEUE_DEPTH + 32'(head_reg[q_lat]));
    end

    fprs_entry_ram u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // shared compare unit: aged level of the head just read
    logic [63:0]          h_id;
    logic [TIME_BITS-1:0] h_time, h_wait;
    logic                 h_crit;
    logic [1:0]           s_op;
    logic [SW-1:0]        s_src;
    logic [2:0]           lvl;
    logic                 better;

    assign h_id   = ram_rdata[EW-1 -: 64];
    assign h_time = ram_rdata[TIME_BITS:1];
    assign h_crit = ram_rdata[0];
    assign h_wait = now_reg - h_time;
    assign s_op   = 2'(scan_reg >> SW);
    assign s_src  = SW'(scan_reg);

    always_comb
    begin
        lvl = base_level(s_op, s_src, h_crit);
        if (48'(h_wait) >= aging_reg)
            lvl = 3'd0;
        else if (s_op != OP_READ)
        begin
            if (s_src != SW'(7) && 48'(h_wait) >= starve_reg)
                lvl = 3'd0;
            else if (streak_reg >= streak_limit_reg)
                lvl = 3'd0;
        end
    end

    assign better = !have_reg || lvl < bpri_reg
                 || (lvl == bpri_reg && (h_time < btime_reg
                 || (h_time == btime_reg && h_id < bid_reg)));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    if (cmd == CMD_DEQ && src_ok)
                        state_next = S_DEQ_RD;
                    else if (cmd == CMD_CHOOSE)
                        state_next = S_SCAN_RD;
                end
            S_DEQ_RD:   state_next = S_DEQ_CHK;
            S_DEQ_CHK:  state_next = S_IDLE;
            S_SCAN_RD:  state_next = S_SCAN_CMP;
            S_SCAN_CMP: state_next = (scan_reg == QW'(NUM_QUEUES - 1)) ? S_DONE : S_SCAN_RD;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            aging_reg        <= '1;
            starve_reg       <= '1;
            streak_limit_reg <= '1;
            streak_reg       <= '0;
            ovalid_reg       <= 1'b0;
            scan_reg         <= '0;
            have_reg         <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_AGING:  aging_reg        <= cfg_data;
                    REG_STARVE: starve_reg       <= cfg_data;
                    REG_STREAK: streak_limit_reg <= cfg_data[15:0];
                    default:    ;
                endcase
            end
            if (finish)
                ovalid_reg <= 1'b1;
            else if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (accept)
                    begin
                        if (ram_we)
                            count_reg[q_in] <= count_reg[q_in] + CW'(1);
                        scan_reg <= '0;
                        have_reg <= 1'b0;
                    end
                S_DEQ_CHK:
                begin
                    if (count_reg[q_lat] != '0 && h_id == id_reg)
                    begin
                        head_reg[q_lat] <= (head_reg[q_lat] == PW'(QUEUE_DEPTH - 1))
                                         ? '0 : head_reg[q_lat] + PW'(1);
                        count_reg[q_lat] <= count_reg[q_lat] - CW'(1);
                        if (upd_reg)
                        begin
                            if (op_reg != OP_READ)
                                streak_reg <= '0;
                            else if (streak_reg != 16'hFFFF)
                                streak_reg <= streak_reg + 16'd1;
                        end
                    end
                end
                S_SCAN_CMP:
                begin
                    if (count_reg[scan_reg] != '0 && better)
                        have_reg <= 1'b1;
                    scan_reg <= scan_reg + QW'(1);
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    op_reg     <= op;
                    src_reg    <= source;
                    id_reg     <= request_id;
                    upd_reg    <= update_streak;
                    now_reg    <= TIME_BITS'(now);
                    found_reg  <= 1'b0;
                    cid_reg    <= '0;
                    cop_reg    <= '0;
                    csrc_reg   <= '0;
                    cpri_reg   <= '0;
                    if (cmd == CMD_ENQ)
                        status_reg <= ram_we ? ST_OK : ST_FULL;
                    else if (cmd == CMD_DEQ)
                        status_reg <= src_ok ? ST_OK : ST_MISMATCH;
                    else
                        status_reg <= ST_OK;
                end
            S_DEQ_CHK:
                status_reg <= (count_reg[q_lat] != '0 && h_id == id_reg)
                            ? ST_OK : ST_MISMATCH;
            S_SCAN_CMP:
                if (count_reg[scan_reg] != '0 && better)
                begin
                    bpri_reg  <= lvl;
                    btime_reg <= h_time;
                    bid_reg   <= h_id;
                    bq_reg    <= scan_reg;
                end
            S_DONE:
                if (have_reg)
                begin
                    found_reg <= 1'b1;
                    cid_reg   <= bid_reg;
                    cop_reg   <= 2'(bq_reg >> SW);
                    csrc_reg  <= 3'(SW'(bq_reg));
                    cpri_reg  <= bpri_reg;
                end
            default: ;
        endcase
    end

    assign out_valid       = ovalid_reg;
    assign status          = status_reg;
    assign found           = found_reg;
    assign chosen_id       = cid_reg;
    assign chosen_op       = cop_reg;
    assign chosen_source   = csrc_reg;
    assign chosen_priority = cpri_reg;

endmodule
`default_nettype wire

/* tb/tb_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_checker: plane scheduler result checker
// Watches the request, result and register channels, keeps its own copy of
// the plane queues, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module tb_checker
    import fprs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [1:0]  op,
    input  wire logic [2:0]  source,
    input  wire logic [63:0] request_id,
    input  wire logic [47:0] enq_time,
    input  wire logic        critical,
    input  wire logic        update_streak,
    input  wire logic [47:0] now,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [1:0]  status,
    input  wire logic        found,
    input  wire logic [63:0] chosen_id,
    input  wire logic [1:0]  chosen_op,
    input  wire logic [2:0]  chosen_source,
    input  wire logic [2:0]  chosen_priority,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [47:0] cfg_data,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [63:0] id;
        logic [1:0]  op;
        logic [2:0]  src;
        logic [2:0]  pri;
    } sched_result_t;

    sched_result_t expected_results[$];

    logic [47:0] aging_lim;
    logic [47:0] starve_lim;
    logic [15:0] streak_lim;
    logic [15:0] streak;
    logic [63:0] q_id   [NUM_QUEUES][QUEUE_DEPTH];
    logic [47:0] q_time [NUM_QUEUES][QUEUE_DEPTH];
    logic        q_crit [NUM_QUEUES][QUEUE_DEPTH];
    int          q_head [NUM_QUEUES];
    int          q_cnt  [NUM_QUEUES];

    assign pending = expected_results.size();

    function automatic logic [2:0] level_of(logic [1:0] o, logic [2:0] s, logic c,
                                            logic [47:0] wait_t);
        logic [2:0] lvl;
        logic urgent;
        urgent = (s == SRC_RECOVERY) || (s == SRC_REPLAY);
        if (urgent && c) lvl = 3'd0;
        else if (s == SRC_USER && o == OP_READ) lvl = 3'd1;
        else if (urgent) lvl = 3'd2;
        else if (s == SRC_USER || s == SRC_MAPPING) lvl = 3'd3;
        else if (s == SRC_MAINT || s == SRC_REFRESH || s == SRC_HOST_REFRESH) lvl = 3'd4;
        else lvl = LOWEST_PRIORITY;
        if (wait_t >= aging_lim) return 3'd0;
        if (o != OP_READ) begin
            // source 7 is exempt from write starvation
            if (s != 3'd7 && wait_t >= starve_lim) return 3'd0;
            if (streak >= streak_lim) return 3'd0;
        end
        return lvl;
    endfunction

    task automatic schedule_request();
        sched_result_t r;
        int qi, slot;
        logic have;
        logic [47:0] best_t, t;
        logic [2:0] lvl;
        r = '0;
        qi = int'(op) * NUM_SOURCES + int'(source);
        if (cmd == CMD_ENQ) begin
            if (q_cnt[qi] >= QUEUE_DEPTH) r.status = ST_FULL;
            else begin
                slot = (q_head[qi] + q_cnt[qi]) % QUEUE_DEPTH;
                q_id[qi][slot] = request_id;
                q_time[qi][slot] = enq_time;
                q_crit[qi][slot] = critical;
                q_cnt[qi]++;
            end
        end else if (cmd == CMD_DEQ) begin
            if (q_cnt[qi] == 0 || q_id[qi][q_head[qi]] != request_id) r.status = ST_MISMATCH;
            else begin
                q_head[qi] = (q_head[qi] + 1) % QUEUE_DEPTH;
                q_cnt[qi]--;
                if (update_streak) begin
                    if (op == OP_READ) begin
                        if (streak != 16'hFFFF) streak++;
                    end else streak = '0;
                end
            end
        end else if (cmd == CMD_CHOOSE) begin
            have = 1'b0;
            best_t = '0;
            for (int k = 0; k < NUM_QUEUES; k++) begin
                if (q_cnt[k] == 0) continue;
                t = q_time[k][q_head[k]];
                lvl = level_of(2'(k / NUM_SOURCES), 3'(k % NUM_SOURCES),
                               q_crit[k][q_head[k]], now - t);
                if (!have || lvl < r.pri || (lvl == r.pri && (t < best_t ||
                    (t == best_t && q_id[k][q_head[k]] < r.id)))) begin
                    have = 1'b1;
                    r.pri = lvl;
                    best_t = t;
                    r.id = q_id[k][q_head[k]];
                    r.op = 2'(k / NUM_SOURCES);
                    r.src = 3'(k % NUM_SOURCES);
                end
            end
            r.found = have;
        end
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            aging_lim  <= '1;
            starve_lim <= '1;
            streak_lim <= '1;
            streak     <= '0;
            fail_count <= 0;
            for (int k = 0; k < NUM_QUEUES; k++) begin
                q_head[k] <= 0;
                q_cnt[k]  <= 0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_AGING:  aging_lim  = cfg_data;
                    REG_STARVE: starve_lim = cfg_data;
                    REG_STREAK: streak_lim = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                sched_result_t e;
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    e = expected_results[0];
                    expected_results.delete(0);
                    compare_field("status", e.status, status);
                    compare_field("found", e.found, found);
                    compare_field("chosen_id", e.id, chosen_id);
                    compare_field("chosen_op", e.op, chosen_op);
                    compare_field("chosen_source", e.src, chosen_source);
                    compare_field("chosen_priority", e.pri, chosen_priority);
                end
            end
            if (in_valid && !in_stall) schedule_request();
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: plane scheduler regression
// Directed and random enqueue, dequeue and choose traffic across several
// register settings with random gaps on both sides; the checker compares.
// ----------------------------------------------------------------------------
module tb_top;
    import fprs_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = CMD_ENQ;
    logic [1:0]  op = '0;
    logic [2:0]  source = '0;
    logic [63:0] request_id = '0;
    logic [47:0] enq_time = '0;
    logic        critical = 1'b0;
    logic        update_streak = 1'b0;
    logic [47:0] now = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic        found;
    logic [63:0] chosen_id;
    logic [1:0]  chosen_op;
    logic [2:0]  chosen_source;
    logic [2:0]  chosen_priority;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_AGING;
    logic [47:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    logic        sink_on = 1'b0;
    int          stall_left = 0;

    // live ids per queue, so dequeues usually hit the head
    logic [63:0] live_ids[NUM_QUEUES][$];
    logic [47:0] clock_now = 48'd1000;

    always #2 clk = ~clk;

    flash_plane_request_scheduler_top u_top (.*);

    tb_checker u_chk (.*);

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stalls in bursts, mostly short and a few long
    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (sink_on && $urandom_range(0, 99) < 25) begin
            out_stall <= 1'b1;
            stall_left <= gap_len();
        end else out_stall <= 1'b0;
    end

    task automatic send_request(logic [1:0] c, logic [1:0] o, logic [2:0] s,
                                logic [63:0] id, logic [47:0] t, logic crit,
                                logic upd, logic [47:0] nw);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        cmd <= c; op <= o; source <= s; request_id <= id;
        enq_time <= t; critical <= crit; update_streak <= upd; now <= nw;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [47:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic random_request();
        int r, qi;
        logic [1:0] o;
        logic [2:0] s;
        logic [63:0] id;
        logic [47:0] t;
        o = 2'($urandom_range(0, 3));
        s = 3'($urandom_range(0, 7));
        qi = int'(o) * NUM_SOURCES + int'(s);
        r = $urandom_range(0, 99);
        clock_now += 48'($urandom_range(0, 300));
        if (r < 40) begin
            id = {$urandom, $urandom};
            if ($urandom_range(0, 9) == 0) t = {$urandom, 16'($urandom)};
            else t = clock_now - 48'($urandom_range(0, 5000));
            if (live_ids[qi].size() < QUEUE_DEPTH)
                live_ids[qi].insert(live_ids[qi].size(), id);
            send_request(CMD_ENQ, o, s, id, t, 1'($urandom), 1'($urandom), clock_now);
        end else if (r < 70) begin
            if (live_ids[qi].size() != 0 && $urandom_range(0, 9) != 0) begin
                id = live_ids[qi][0];
                live_ids[qi].delete(0);
            end else begin
                id = {$urandom, $urandom};
            end
            send_request(CMD_DEQ, o, s, id, 48'($urandom), 1'($urandom),
                         $urandom_range(0, 3) != 0, clock_now);
        end else if (r < 97) begin
            send_request(CMD_CHOOSE, o, s, {$urandom, $urandom}, 48'($urandom),
                         1'($urandom), 1'($urandom), clock_now);
        end else begin
            send_request(2'd3, o, s, {$urandom, $urandom}, {$urandom, 16'($urandom)},
                         1'($urandom), 1'($urandom), {$urandom, 16'($urandom)});
        end
    endtask

    initial begin
        logic [47:0] ages[5];
        logic [15:0] streaks[5];
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        sink_on = 1'b1;

        // directed: empty choose, extremes, full queue, mismatch, unknown command
        send_request(CMD_CHOOSE, 2'd0, 3'd0, '0, '0, 1'b0, 1'b0, '0);
        send_request(CMD_DEQ, 2'd3, 3'd7, '1, '1, 1'b1, 1'b1, '1);
        send_request(CMD_ENQ, 2'd0, 3'd2, '1, '1, 1'b1, 1'b1, '1);
        send_request(CMD_ENQ, 2'd3, 3'd7, '0, '0, 1'b0, 1'b0, '0);
        send_request(CMD_CHOOSE, 2'd0, 3'd0, '0, '0, 1'b0, 1'b0, 48'd5);
        for (int k = 0; k < QUEUE_DEPTH + 1; k++)
            send_request(CMD_ENQ, 2'd1, 3'd0, 64'(k), 48'(k), 1'b0, 1'b0, '0);
        send_request(CMD_DEQ, 2'd1, 3'd0, 64'd7, '0, 1'b0, 1'b1, '0);
        send_request(CMD_DEQ, 2'd1, 3'd0, 64'd0, '0, 1'b0, 1'b1, '0);
        send_request(2'd3, 2'd3, 3'd7, '1, '1, 1'b1, 1'b1, '1);
        send_request(CMD_CHOOSE, 2'd0, 3'd0, '0, '0, 1'b0, 1'b0, '1);
        drain();
        // enter directed leftovers into the ids the random part dequeues
        for (int k = 1; k < QUEUE_DEPTH; k++)
            live_ids[1*NUM_SOURCES].insert(live_ids[1*NUM_SOURCES].size(), 64'(k));
        live_ids[2].insert(live_ids[2].size(), '1);
        live_ids[3*NUM_SOURCES+7].insert(live_ids[3*NUM_SOURCES+7].size(), '0);

        ages = '{48'hFFFF_FFFF_FFFF, 48'd0, 48'd2000, 48'd40000, 48'hFFFF_FFFF_FFFE};
        streaks = '{16'hFFFF, 16'd0, 16'd3, 16'd1, 16'd20};
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_AGING, ages[ph]);
            write_reg(REG_STARVE, ages[(ph + 2) % 5]);
            write_reg(REG_STREAK, {32'd0, streaks[ph]});
            for (int n = 0; n < 370; n++) random_request();
            drain();
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #10000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
